[rtl/core/swp_pkg.sv]
// swp_pkg: shared types and constants for the swing pivot segment detector
// holds payload structs, config register indexes and fixed field widths
// no dependencies
package swp_pkg;

    localparam int PRICE_BITS    = 32;
    localparam int INDEX_BITS    = 16;
    localparam int CFG_BITS      = 5;
    localparam int CFG_ADDR_BITS = 1;

    // config register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LOOKBACK    = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_USE_SHADOWS = 1'b1;

    localparam logic [CFG_BITS-1:0] LOOKBACK_RST    = 5'd2;
    localparam logic                USE_SHADOWS_RST = 1'b1;

    // segment kinds
    localparam logic KIND_LOW  = 1'b0;
    localparam logic KIND_HIGH = 1'b1;

    // results a single bar can cause, and output queue depth
    localparam int MAX_RESULTS = 2;
    localparam int OUTQ_DEPTH  = 4;

    typedef logic [PRICE_BITS-1:0] t_price;
    typedef logic [INDEX_BITS-1:0] t_index;

    typedef struct packed {
        t_price high_price;
        t_price low_price;
        t_price close_price;
        logic   series_start;
    } t_in_item;

    typedef struct packed {
        logic   segment_kind;
        t_index start_index;
        t_price start_price;
        t_index end_index;
        t_price end_price;
        logic   last_of_run;
    } t_out_item;

    typedef struct packed {
        logic   is_low;
        logic   is_high;
        t_index centre_idx;
        t_price hi_price;
        t_price lo_price;
    } t_pivot_evt;

    typedef struct packed {
        logic      lo_vld;
        logic      hi_vld;
        t_out_item lo_seg;
        t_out_item hi_seg;
    } t_seg_wr;

endpackage

[rtl/core/swing_pivot_segment_detector_core.sv]
// swing_pivot_segment_detector_core: top level of the swing pivot segment detector
// depends on swp_pkg, swp_window, swp_pivot, swp_outq

// One bar is accepted per clock. A bar enters the shift window at the edge it is
// accepted; in the next cycle the centre bar is tested against all neighbours
// in parallel and any segments are written to a four-entry result queue, so a
// segment is registered in the queue before it appears on the output. The input
// stalls during reset and when the queue could not absorb two results from the
// bar under test plus two from a new bar. Bars with no pivot flow at one per cycle;
// a bar that yields segments stalls the input even with the receiver ready,
// since its segments are still queued while the following bar is under test.
// Config writes should occur only while idle.
module swing_pivot_segment_detector_core #(
    parameter int MAX_LOOKBACK = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  swp_pkg::t_in_item                   i_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output swp_pkg::t_out_item                  o_item,
    input  logic                                i_cfg_we,
    input  logic [swp_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [swp_pkg::CFG_BITS-1:0]        i_cfg_wdata
);
    import swp_pkg::*;

    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    logic [CFG_BITS-1:0] r_lookback;
    logic                r_use_shadows;

    logic       accept;
    logic       pend;
    logic       room;
    logic       evt_vld;
    t_pivot_evt evt;
    t_seg_wr    seg_wr;
    logic [CNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookback    <= LOOKBACK_RST;
            r_use_shadows <= USE_SHADOWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LOOKBACK:    r_lookback    <= i_cfg_wdata;
                CFG_USE_SHADOWS: r_use_shadows <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_stall = !room || !i_rst_n;
    assign accept  = i_valid && !o_stall;

    swp_window #(
        .MAX_LOOKBACK(MAX_LOOKBACK)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_item),
        .i_use_shadows(r_use_shadows),
        .i_lookback   (r_lookback),
        .o_pend       (pend),
        .o_evt_vld    (evt_vld),
        .o_evt        (evt)
    );

    swp_pivot u_pivot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept && i_item.series_start),
        .i_evt_vld(evt_vld),
        .i_evt    (evt),
        .o_wr     (seg_wr)
    );

    swp_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (seg_wr),
        .i_pend (pend),
        .o_room (room),
        .o_valid(o_valid),
        .o_item (o_item),
        .i_stall(i_stall),
        .o_count(q_count)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNT_W'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_pair_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seg_wr.lo_vld && seg_wr.hi_vld) |-> (q_count <= CNT_W'(OUTQ_DEPTH - MAX_RESULTS)))
        else $error("segment pair written without room");

    a_start_no_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.series_start) |=> !(seg_wr.lo_vld || seg_wr.hi_vld))
        else $error("segment emitted from first bar of a series");

    a_eval_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt_vld |-> $past(accept))
        else $error("pivot test without an accepted bar");

endmodule

[rtl/core/swp_window.sv]
// swp_window: bar shift window, bar counter and centre-bar extremum test
// depends on swp_pkg
module swp_window #(
    parameter int MAX_LOOKBACK = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  swp_pkg::t_in_item               i_item,
    input  logic                            i_use_shadows,
    input  logic [swp_pkg::CFG_BITS-1:0]    i_lookback,
    output logic                            o_pend,
    output logic                            o_evt_vld,
    output swp_pkg::t_pivot_evt             o_evt
);
    import swp_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_LOOKBACK + 1;
    localparam int LB_W      = $clog2(MAX_LOOKBACK + 1);
    localparam int WIN_IW    = $clog2(WIN_DEPTH);
    localparam int POS_W     = LB_W + 1;
    localparam int CL_W      = (LB_W > CFG_BITS) ? LB_W : CFG_BITS;

    t_price r_hi [WIN_DEPTH];
    t_price r_lo [WIN_DEPTH];
    t_index r_bar_count;
    t_index n_bar_count;
    logic   r_eval;

    logic [CL_W-1:0]  lb_raw;
    logic [CL_W-1:0]  lb_clamp;
    logic [LB_W-1:0]  lb;
    logic [POS_W-1:0] lb_pos;
    logic [POS_W-1:0] lb_span;
    t_price           centre_hi;
    t_price           centre_lo;
    logic             is_high;
    logic             is_low;

    always_comb begin
        if (i_item.series_start) begin
            n_bar_count = INDEX_BITS'(1);
        end else if (r_bar_count == '1) begin
            n_bar_count = r_bar_count;
        end else begin
            n_bar_count = r_bar_count + INDEX_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_count <= '0;
            r_eval      <= 1'b0;
        end else begin
            r_eval <= i_accept;
            if (i_accept) begin
                r_bar_count <= n_bar_count;
            end
        end
    end

    // a series start flushes older bars to zero as the new bar enters
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hi[0] <= i_use_shadows ? i_item.high_price : i_item.close_price;
            r_lo[0] <= i_use_shadows ? i_item.low_price  : i_item.close_price;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                r_hi[i] <= i_item.series_start ? '0 : r_hi[i-1];
                r_lo[i] <= i_item.series_start ? '0 : r_lo[i-1];
            end
        end
    end

    always_comb begin
        lb_raw = CL_W'(i_lookback);
        if (lb_raw == '0) begin
            lb_clamp = CL_W'(1);
        end else if (lb_raw > CL_W'(MAX_LOOKBACK)) begin
            lb_clamp = CL_W'(MAX_LOOKBACK);
        end else begin
            lb_clamp = lb_raw;
        end
        lb      = LB_W'(lb_clamp);
        lb_pos  = POS_W'(lb);
        lb_span = {lb, 1'b0};
    end

    assign centre_hi = r_hi[WIN_IW'(lb)];
    assign centre_lo = r_lo[WIN_IW'(lb)];

    // every bar within lookback of the centre, compared in parallel
    always_comb begin
        is_high = 1'b1;
        is_low  = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if ((POS_W'(i) <= lb_span) && (POS_W'(i) != lb_pos)) begin
                if (r_hi[i] > centre_hi) begin
                    is_high = 1'b0;
                end
                if (r_lo[i] < centre_lo) begin
                    is_low = 1'b0;
                end
            end
        end
    end

    assign o_pend    = r_eval;
    assign o_evt_vld = r_eval && (r_bar_count >= INDEX_BITS'({lb, 1'b1}));

    always_comb begin
        o_evt.is_low     = is_low;
        o_evt.is_high    = is_high;
        o_evt.centre_idx = r_bar_count - INDEX_BITS'(lb) - INDEX_BITS'(1);
        o_evt.hi_price   = centre_hi;
        o_evt.lo_price   = centre_lo;
    end

endmodule

[rtl/core/swp_pivot.sv]
// swp_pivot: last pivot of each kind and segment building
// depends on swp_pkg
module swp_pivot (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_evt_vld,
    input  swp_pkg::t_pivot_evt i_evt,
    output swp_pkg::t_seg_wr    o_wr
);
    import swp_pkg::*;

    logic   r_lo_vld;
    t_index r_lo_idx;
    t_price r_lo_price;
    logic   r_hi_vld;
    t_index r_hi_idx;
    t_price r_hi_price;

    logic lo_piv;
    logic hi_piv;
    logic lo_emit;
    logic hi_emit;

    assign lo_piv  = i_evt_vld && i_evt.is_low;
    assign hi_piv  = i_evt_vld && i_evt.is_high;
    assign lo_emit = lo_piv && r_lo_vld;
    assign hi_emit = hi_piv && r_hi_vld;

    // a series start clears at the same edge an older bar is evaluated, and wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_vld <= 1'b0;
            r_hi_vld <= 1'b0;
        end else if (i_clear) begin
            r_lo_vld <= 1'b0;
            r_hi_vld <= 1'b0;
        end else begin
            if (lo_piv) begin
                r_lo_vld <= 1'b1;
            end
            if (hi_piv) begin
                r_hi_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lo_piv) begin
            r_lo_idx   <= i_evt.centre_idx;
            r_lo_price <= i_evt.lo_price;
        end
        if (hi_piv) begin
            r_hi_idx   <= i_evt.centre_idx;
            r_hi_price <= i_evt.hi_price;
        end
    end

    always_comb begin
        o_wr.lo_vld = lo_emit;
        o_wr.hi_vld = hi_emit;

        o_wr.lo_seg.segment_kind = KIND_LOW;
        o_wr.lo_seg.start_index  = r_lo_idx;
        o_wr.lo_seg.start_price  = r_lo_price;
        o_wr.lo_seg.end_index    = i_evt.centre_idx;
        o_wr.lo_seg.end_price    = i_evt.lo_price;
        o_wr.lo_seg.last_of_run  = !hi_emit;

        o_wr.hi_seg.segment_kind = KIND_HIGH;
        o_wr.hi_seg.start_index  = r_hi_idx;
        o_wr.hi_seg.start_price  = r_hi_price;
        o_wr.hi_seg.end_index    = i_evt.centre_idx;
        o_wr.hi_seg.end_price    = i_evt.hi_price;
        o_wr.hi_seg.last_of_run  = 1'b1;
    end

endmodule

[rtl/core/swp_outq.sv]
// swp_outq: small result queue taking up to two segments per cycle
// depends on swp_pkg
module swp_outq (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  swp_pkg::t_seg_wr                      i_wr,
    input  logic                                  i_pend,
    output logic                                  o_room,
    output logic                                  o_valid,
    output swp_pkg::t_out_item                    o_item,
    input  logic                                  i_stall,
    output logic [$clog2(swp_pkg::OUTQ_DEPTH+1)-1:0] o_count
);
    import swp_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int WN_W  = $clog2(MAX_RESULTS + 1);

    t_out_item          r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic [WN_W-1:0]    wn;
    logic               pop;
    t_out_item          e0;
    logic [CNT_W:0]     need;

    assign wn  = WN_W'(i_wr.lo_vld) + WN_W'(i_wr.hi_vld);
    assign pop = o_valid && !i_stall;
    assign e0  = i_wr.lo_vld ? i_wr.lo_seg : i_wr.hi_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(wn);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(wn) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wn != '0) begin
            r_mem[r_wr_ptr] <= e0;
        end
        if (i_wr.lo_vld && i_wr.hi_vld) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_wr.hi_seg;
        end
    end

    // reserve room for the bar now being evaluated and for one more
    assign need   = {1'b0, r_count} + (i_pend ? (CNT_W+1)'(MAX_RESULTS) : '0);
    assign o_room = need <= (CNT_W+1)'(OUTQ_DEPTH - MAX_RESULTS);

    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule
